/* src/rws_pkg.sv */
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and constants of the resampling wheel selector: beat field
// widths and the action codes.
// ----------------------------------------------------------------------------
package rws_pkg;

  // Beat field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned COUNT_W  = 9;

  // Reset value of the particle count register
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

  // Action codes carried by an input beat
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_DRAW  = 2'd2
  } action_e;

endpackage

/* src/rws_ram.sv */
// ----------------------------------------------------------------------------
// rws_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/resampling_wheel_selector.sv */
// ----------------------------------------------------------------------------
// resampling_wheel_selector
// Particle-filter resampling wheel over a weight RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid_i / in_ready_o) carry an action. A load writes one
//   weight into the RAM and tracks the largest weight (a load to entry zero
//   restarts it). A start places the wheel at start_index_i, clamped to the
//   particle count, and clears the accumulator. A draw adds the scaled random
//   step to the accumulator, walks the ring and returns one beat on
//   selected_index_o (out_valid_o / out_ready_i). Loads and starts return
//   nothing.
//   cfg_we_i writes the particle count at once; write it only while idle.
//   A draw reads the first weight at accept, adds the step in the add state
//   and then walks: the walk reads one weight per cycle from the single RAM
//   read port, compares and subtracts. At most 4*count steps are taken per
//   draw.
//   The output register lets the next beat enter while a result waits. If a
//   draw finishes while the previous result is still not taken, the walk
//   holds until out_ready_i frees the output register.
//   Reset clears the control state, the largest weight, the accumulator and
//   the wheel position, and sets the count to 256. The weight RAM is not
//   cleared: an entry must be loaded before a draw reads it.
// ----------------------------------------------------------------------------
module resampling_wheel_selector #(
  parameter int unsigned MAX_PARTICLES = 256,
  parameter int unsigned WEIGHT_BITS   = 32,
  parameter int unsigned RANDOM_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [rws_pkg::COUNT_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rws_pkg::ACTION_W-1:0]    action_i,
  input  logic [rws_pkg::INDEX_W-1:0]     entry_index_i,
  input  logic [rws_pkg::WEIGHT_W-1:0]    weight_i,
  input  logic [rws_pkg::INDEX_W-1:0]     start_index_i,
  input  logic [rws_pkg::FRAC_W-1:0]      random_fraction_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rws_pkg::INDEX_W-1:0]     selected_index_o
);

  localparam int unsigned AW     = $clog2(MAX_PARTICLES);
  localparam int unsigned CW_RAW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned CW     = (CW_RAW > rws_pkg::COUNT_W) ? CW_RAW : rws_pkg::COUNT_W;
  localparam int unsigned SW     = CW + 2;
  localparam int unsigned BW     = WEIGHT_BITS + 2;
  localparam int unsigned PW     = RANDOM_BITS + WEIGHT_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK
  } state_e;

  state_e                        state_q;
  logic [rws_pkg::COUNT_W-1:0]   count_q;
  logic [WEIGHT_BITS-1:0]        largest_q;
  logic [BW-1:0]                 beta_q;
  logic [AW-1:0]                 pos_q;
  logic [SW-1:0]                 steps_q;
  logic [PW-1:0]                 prod_q;
  logic                          out_valid_q;
  logic [rws_pkg::INDEX_W-1:0]   sel_q;

  logic                          in_fire;
  rws_pkg::action_e              action;
  logic [CW-1:0]                 live_count;
  logic [CW-1:0]                 count_ext;
  logic [SW-1:0]                 step_limit;
  logic [WEIGHT_BITS-1:0]        load_weight;
  logic                          load_ok;
  logic [CW-1:0]                 start_ext;
  logic [CW-1:0]                 start_pos;
  logic [AW-1:0]                 draw_pos;
  logic [PW-1:0]                 prod_shift;
  logic [BW-1:0]                 beta_inc;
  logic [WEIGHT_BITS-1:0]        rd_weight;
  logic [BW-1:0]                 rd_weight_ext;
  logic                          beta_gt;
  logic                          runaway;
  logic                          walk_done;
  logic                          out_free;
  logic                          deliver;
  logic [CW-1:0]                 pos_inc;
  logic [AW-1:0]                 next_pos;
  logic                          ram_we;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign action     = rws_pkg::action_e'(action_i);

  // Clamp the particle count to the size of the store; a count of zero acts as one
  always_comb begin
    count_ext = CW'(count_q);
    if (count_ext == '0) begin
      live_count = CW'(1);
    end else if (count_ext > CW'(MAX_PARTICLES)) begin
      live_count = CW'(MAX_PARTICLES);
    end else begin
      live_count = count_ext;
    end
  end

  assign step_limit = {live_count, 2'b00};

  // Load: mask the weight and drop indices beyond the store
  assign load_weight = WEIGHT_BITS'(weight_i);
  assign load_ok     = CW'(entry_index_i) < CW'(MAX_PARTICLES);
  assign ram_we      = in_fire && (action == rws_pkg::ACT_LOAD) && load_ok;

  // Start: clamp the position to count-1
  assign start_ext = CW'(start_index_i);
  assign start_pos = (start_ext > live_count - CW'(1)) ? live_count - CW'(1) : start_ext;

  // Draw: move the wheel to entry zero if the count shrank
  assign draw_pos = (CW'(pos_q) >= live_count) ? '0 : pos_q;

  // Scaled step: frac * 2 * largest / 2^RANDOM_BITS, truncated
  assign prod_shift = prod_q >> (RANDOM_BITS - 1);
  assign beta_inc   = BW'(prod_shift);

  // Walk: compare the accumulator against the weight under the wheel
  assign rd_weight_ext = BW'(rd_weight);
  assign beta_gt       = beta_q > rd_weight_ext;
  assign runaway       = steps_q >= step_limit;
  assign walk_done     = !beta_gt || runaway;
  assign out_free      = !out_valid_q || out_ready_i;
  assign deliver       = (state_q == S_WALK) && walk_done && out_free;
  assign pos_inc       = CW'(pos_q) + CW'(1);
  assign next_pos      = (pos_inc >= live_count) ? '0 : AW'(pos_inc);

  // Weight RAM read port: first entry at draw accept, then one per step
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = draw_pos;
    if (state_q == S_IDLE) begin
      ram_re    = in_fire && (action == rws_pkg::ACT_DRAW);
      ram_raddr = draw_pos;
    end else if (state_q == S_WALK) begin
      ram_re    = !walk_done;
      ram_raddr = next_pos;
    end
  end

  rws_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_PARTICLES)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (load_weight),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_weight)
  );

  // Multiply the random fraction by the largest weight at draw accept
  always_ff @(posedge clk_i) begin
    if (in_fire && (action == rws_pkg::ACT_DRAW)) begin
      prod_q <= PW'(RANDOM_BITS'(random_fraction_i)) * PW'(largest_q);
    end
  end

  // Sequencer: state, wheel registers and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= rws_pkg::COUNT_RESET;
      largest_q   <= '0;
      beta_q      <= '0;
      pos_q       <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
      sel_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      // Raise the output beat on delivery, drop it once taken
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (action)
              rws_pkg::ACT_LOAD: begin
                if (load_ok && ((entry_index_i == '0) || (load_weight > largest_q))) begin
                  largest_q <= load_weight;
                end
              end
              rws_pkg::ACT_START: begin
                pos_q  <= AW'(start_pos);
                beta_q <= '0;
              end
              rws_pkg::ACT_DRAW: begin
                pos_q   <= draw_pos;
                state_q <= S_ADD;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          beta_q  <= beta_q + beta_inc;
          steps_q <= '0;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (walk_done) begin
            // Hold until the output register is free, then deliver
            if (out_free) begin
              if (beta_gt) begin
                beta_q <= '0;
              end
              sel_q       <= rws_pkg::INDEX_W'(pos_q);
              state_q     <= S_IDLE;
            end
          end else begin
            // Advance one entry around the ring
            beta_q  <= beta_q - rd_weight_ext;
            pos_q   <= next_pos;
            steps_q <= steps_q + SW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign selected_index_o = sel_q;

endmodule
